// File: src/jue_pkg.sv
// Shared types and constants of the JSON \u escape to UTF-8 decoder.
// Used by the front end, the queue and the back end; depends on nothing.
`timescale 1ns / 1ps

package jue_pkg;

	// Error codes carried with each output byte.
	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_NO_LOW  = 3'd1,
		ERR_BAD_LOW = 3'd2,
		ERR_LONE    = 3'd3,
		ERR_TRUNC   = 3'd4
	} err_t;

	// Characters that steer the escape decoder.
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_U   = 8'h75;

	// Depth of the queue between front and back end.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// One queue entry: the 1 to 4 output bytes caused by one input request.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		err_t            err;
		logic            str_end;
	} entry_t;

endpackage

// File: src/jue_in_if.sv
// Input channel: one string byte per request with its end-of-string mark.
// Depends on nothing.
`timescale 1ns / 1ps

interface jue_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       string_end;

	modport source (output valid, in_char, string_end, input ready);
	modport sink (input valid, in_char, string_end, output ready);
endinterface

// File: src/jue_out_if.sv
// Output channel: one decoded UTF-8 byte per request with its status flags.
// Depends on nothing.
`timescale 1ns / 1ps

interface jue_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       run_last;
	logic       string_last;

	modport source (output valid, out_byte, error_code, run_last, string_last, input ready);
	modport sink (input valid, out_byte, error_code, run_last, string_last, output ready);
endinterface

// File: src/json_unicode_escape_to_utf8_unit.sv
// Top level of the JSON \u escape to UTF-8 decoder.
// Uses jue_pkg, jue_in_if, jue_out_if, jue_front, jue_fifo, jue_back.
`timescale 1ns / 1ps

// Takes one byte of a JSON string body per cycle on chars and gives the
// decoded UTF-8 bytes, one per cycle while bytes is ready, on bytes. Plain
// bytes pass through; \uXXXX escapes and surrogate pairs become 1 to 4
// UTF-8 bytes, emitted on the request that completes the escape. Input is
// taken every cycle while the four-entry queue between the decoder and the
// output stage has room; output runs at one byte per cycle while bytes is
// ready, so a request that yields n bytes takes n output slots and the
// sustained input rate is set by the mean output bytes per input byte (at
// most 1 for well formed text). An error gives one zero byte with its code,
// closing the string; the rest of that string is dropped until its end
// byte. Results are registered in the queue, then in the output register.
module json_unicode_escape_to_utf8_unit (
	input  logic      clk,
	input  logic      arst_n,
	jue_in_if.sink    chars,
	jue_out_if.source bytes
);

	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	jue_pkg::entry_t push_entry;
	jue_pkg::entry_t head;

	// Escape decoding.
	jue_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.fifo_full (full),
		.push      (push),
		.entry     (push_entry)
	);

	// Decoupling queue.
	jue_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	// Byte serializer and output register.
	jue_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.bytes  (bytes)
	);

endmodule

// File: src/jue_front.sv
// Front end: accepts string bytes, runs the escape state machine and
// builds one queue entry per request that yields output. Uses jue_pkg, jue_in_if.
`timescale 1ns / 1ps

module jue_front (
	input  logic            clk,
	input  logic            arst_n,
	jue_in_if.sink          chars,
	input  logic            fifo_full,
	output logic            push,
	output jue_pkg::entry_t entry
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BSL,
		PH_HEX1,
		PH_WANT_BS,
		PH_WANT_U,
		PH_HEX2,
		PH_DROP
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [11:0] accum_q, accum_d;
	logic [1:0]  digits_q, digits_d;
	logic [9:0]  high_q, high_d;

	logic            accept;
	logic [7:0]      c;
	logic            fin;
	logic [15:0]     v;
	logic            in_high;
	logic            in_low;
	logic            use_cp;
	logic [20:0]     cp;
	logic [3:0][7:0] bytes;
	logic [2:0]      nbytes;
	jue_pkg::err_t   err;

	// Value of one hex digit; anything else counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [3:0] r;
		r = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) r = 4'(ch - 8'h30);
		else if (ch >= 8'h41 && ch <= 8'h46) r = 4'(ch - 8'h37);
		else if (ch >= 8'h61 && ch <= 8'h66) r = 4'(ch - 8'h57);
		return r;
	endfunction

	assign chars.ready = !fifo_full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.in_char;
	assign fin         = chars.string_end;
	assign v           = {accum_q, hex_value(c)};
	assign in_high     = (v >= 16'hD800) && (v <= 16'hDBFF);
	assign in_low      = (v >= 16'hDC00) && (v <= 16'hDFFF);

	// Next state and output bytes for the byte on the input.
	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		digits_d = digits_q;
		high_d   = high_q;
		err      = jue_pkg::ERR_NONE;
		bytes    = '0;
		nbytes   = 3'd0;
		use_cp   = 1'b0;
		cp       = '0;

		unique case (phase_q)
			PH_BSL: begin
				if (c == jue_pkg::CH_U) begin
					if (fin) begin
						err = jue_pkg::ERR_TRUNC;
					end else begin
						phase_d  = PH_HEX1;
						accum_d  = '0;
						digits_d = '0;
					end
				end else if (c == jue_pkg::CH_BSL) begin
					// The first backslash goes out, the second is held.
					bytes[0] = jue_pkg::CH_BSL;
					nbytes   = 3'd1;
					if (fin) begin
						bytes[1] = jue_pkg::CH_BSL;
						nbytes   = 3'd2;
					end
				end else begin
					bytes[0] = jue_pkg::CH_BSL;
					bytes[1] = c;
					nbytes   = 3'd2;
					phase_d  = PH_IDLE;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (digits_q != 2'd3) begin
					if (fin) begin
						err = jue_pkg::ERR_TRUNC;
					end else begin
						accum_d  = v[11:0];
						digits_d = digits_q + 2'd1;
					end
				end else begin
					accum_d  = '0;
					digits_d = '0;
					if (phase_q == PH_HEX1) begin
						if (in_high) begin
							if (fin) begin
								err = jue_pkg::ERR_NO_LOW;
							end else begin
								high_d  = v[9:0];
								phase_d = PH_WANT_BS;
							end
						end else if (in_low) begin
							err = jue_pkg::ERR_LONE;
						end else begin
							cp      = {5'd0, v};
							use_cp  = 1'b1;
							phase_d = PH_IDLE;
						end
					end else begin
						if (!in_low) begin
							err = jue_pkg::ERR_BAD_LOW;
						end else begin
							// Surrogate pair: 0x10000 plus both ten-bit halves.
							cp      = 21'h10000 + {1'b0, high_q, v[9:0]};
							use_cp  = 1'b1;
							high_d  = '0;
							phase_d = PH_IDLE;
						end
					end
				end
			end
			PH_WANT_BS: begin
				if (c == jue_pkg::CH_BSL && !fin) phase_d = PH_WANT_U;
				else err = jue_pkg::ERR_NO_LOW;
			end
			PH_WANT_U: begin
				if (c == jue_pkg::CH_U) begin
					if (fin) begin
						err = jue_pkg::ERR_TRUNC;
					end else begin
						phase_d  = PH_HEX2;
						accum_d  = '0;
						digits_d = '0;
					end
				end else begin
					err = jue_pkg::ERR_NO_LOW;
				end
			end
			PH_DROP: begin
			end
			default: begin
				if (c == jue_pkg::CH_BSL && !fin) begin
					phase_d = PH_BSL;
				end else begin
					bytes[0] = c;
					nbytes   = 3'd1;
					phase_d  = PH_IDLE;
				end
			end
		endcase

		// UTF-8 encoding of a finished code point.
		if (use_cp) begin
			if (cp < 21'h80) begin
				bytes[0] = cp[7:0];
				nbytes   = 3'd1;
			end else if (cp < 21'h800) begin
				bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
				bytes[1] = 8'h80 | {2'd0, cp[5:0]};
				nbytes   = 3'd2;
			end else if (cp < 21'h10000) begin
				bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
				bytes[1] = 8'h80 | {2'd0, cp[11:6]};
				bytes[2] = 8'h80 | {2'd0, cp[5:0]};
				nbytes   = 3'd3;
			end else begin
				bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
				bytes[1] = 8'h80 | {2'd0, cp[17:12]};
				bytes[2] = 8'h80 | {2'd0, cp[11:6]};
				bytes[3] = 8'h80 | {2'd0, cp[5:0]};
				nbytes   = 3'd4;
			end
		end

		// An error or string end clears the state; an error mid-string enters PH_DROP.
		if (err != jue_pkg::ERR_NONE || fin) begin
			phase_d  = (err != jue_pkg::ERR_NONE && !fin) ? PH_DROP : PH_IDLE;
			accum_d  = '0;
			digits_d = '0;
			high_d   = '0;
		end
	end

	// Queue entry for this request.
	always_comb begin
		push = accept && (err != jue_pkg::ERR_NONE || nbytes != 3'd0);
		if (err != jue_pkg::ERR_NONE) begin
			entry.bytes    = '0;
			entry.last_idx = 2'd0;
			entry.err      = err;
			entry.str_end  = 1'b1;
		end else begin
			entry.bytes    = bytes;
			entry.last_idx = 2'(nbytes - 3'd1);
			entry.err      = jue_pkg::ERR_NONE;
			entry.str_end  = fin;
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			accum_q  <= '0;
			digits_q <= '0;
			high_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			digits_q <= digits_d;
			high_q   <= high_d;
		end
	end

	// A dropped string yields nothing.
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_DROP |-> !push)
		else $error("front pushed while dropping a string");

	// Entries come only from accepted requests.
	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("front pushed without an accepted request");

	// Every string end leaves the decoder idle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fin |=> phase_q == PH_IDLE && digits_q == 2'd0)
		else $error("state not cleared after string end");

endmodule

// File: src/jue_fifo.sv
// Short queue of decoded entries between front and back end.
// Uses jue_pkg.
`timescale 1ns / 1ps

module jue_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jue_pkg::entry_t push_entry,
	input  logic            pop,
	output jue_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	localparam int unsigned CNT_W = jue_pkg::QPTR_W + 1;

	jue_pkg::entry_t             mem_q [jue_pkg::QUEUE_DEPTH];
	logic [jue_pkg::QPTR_W-1:0]  wr_q;
	logic [jue_pkg::QPTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]            count_q;

	assign full  = (count_q == CNT_W'(jue_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: src/jue_back.sv
// Back end: sends each queue entry's bytes one per cycle while output
// is ready, via a registered output stage. Uses jue_pkg, jue_out_if.
`timescale 1ns / 1ps

module jue_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jue_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	jue_out_if.source       bytes
);

	logic       mid_entry;
	logic [1:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [2:0] err_q;
	logic       run_last_q;
	logic       str_last_q;
	logic       advance;
	logic       at_last;

	assign advance   = !empty && (!valid_q || bytes.ready);
	assign at_last   = (pos_q == head.last_idx);
	assign pop       = advance && at_last;
	assign mid_entry = (pos_q != 2'd0);

	assign bytes.valid       = valid_q;
	assign bytes.out_byte    = byte_q;
	assign bytes.error_code  = err_q;
	assign bytes.run_last    = run_last_q;
	assign bytes.string_last = str_last_q;

	// Byte position inside the head entry and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
			pos_q   <= at_last ? 2'd0 : pos_q + 2'd1;
		end else if (bytes.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q     <= head.bytes[pos_q];
			err_q      <= head.err;
			run_last_q <= at_last;
			str_last_q <= at_last && head.str_end;
		end
	end

	// The end of a string is also the end of its request.
	a_str_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && str_last_q |-> run_last_q)
		else $error("string end not on a request end");

	// Error results are single zero bytes closing the string.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && err_q != jue_pkg::ERR_NONE |-> byte_q == 8'd0 && str_last_q)
		else $error("malformed error result");

	// An entry partly sent stays at the head of the queue.
	a_mid_entry: assert property (@(posedge clk) disable iff (!arst_n)
		mid_entry |-> !empty)
		else $error("queue head lost in the middle of an entry");

endmodule
